FILE: hw/rtl/ssd_pkg.sv
// ---------------------------------------------------------------------------
// ssd_pkg: shared types and constants for the seven-segment encoder
// Digit count, overflow limit, segment codes and the pipeline word.
// ---------------------------------------------------------------------------
package ssd_pkg;

  // Decimal digits the display is sized for (1 to 10)
  localparam int NUM_DIGITS = 7;

  // Display geometry
  localparam int POSITIONS  = 8;
  localparam int DIGIT_POS  = POSITIONS - 1;
  localparam int ND_CLAMP   = (NUM_DIGITS < 1) ? 1 : ((NUM_DIGITS > 10) ? 10 : NUM_DIGITS);
  // Digits that have a position of their own; higher ones are dropped
  localparam int DIG_STAGES = (ND_CLAMP < DIGIT_POS) ? ND_CLAMP : DIGIT_POS;
  // First position that carries a digit
  localparam int FIRST_POS  = POSITIONS - DIG_STAGES;

  localparam int MAG_W   = 32;
  localparam int LIMIT_W = 36;

  // 10**n - 1, worked out at elaboration
  function automatic logic [LIMIT_W-1:0] max_decimal(input int n);
    logic [LIMIT_W-1:0] acc;
    acc = LIMIT_W'(1);
    for (int i = 0; i < n; i++) begin
      acc = LIMIT_W'(acc * LIMIT_W'(10));
    end
    return LIMIT_W'(acc - LIMIT_W'(1));
  endfunction

  localparam logic [LIMIT_W-1:0] LIMIT = max_decimal(ND_CLAMP);

  // floor(x / 10) == (x * RECIP_10) >> RECIP_SHIFT for every 32-bit x
  localparam logic [MAG_W-1:0] RECIP_10    = 32'hCCCC_CCCD;
  localparam int               RECIP_SHIFT = 35;

  // Segment codes, gfedcba
  localparam logic [7:0] SEG_BLANK = 8'h00;
  localparam logic [7:0] SEG_MINUS = 8'h40;
  localparam logic [7:0] SEG_LOW_O = 8'h5C;
  localparam logic [7:0] SEG_CAP_L = 8'h38;

  // Positions of the overflow text
  localparam int POS_O = 3;
  localparam int POS_L = 4;

  // Word carried down the pipeline
  typedef struct packed {
    logic                             neg;
    logic                             ovf;
    logic [MAG_W-1:0]                 rest;
    logic [DIG_STAGES-1:0][3:0]       digits;
  } word_t;

  // Decimal digit to gfedcba pattern
  function automatic logic [7:0] seg_pattern(input logic [3:0] d);
    logic [7:0] p;
    unique case (d)
      4'd0:    p = 8'h3F;
      4'd1:    p = 8'h06;
      4'd2:    p = 8'h5B;
      4'd3:    p = 8'h4F;
      4'd4:    p = 8'h66;
      4'd5:    p = 8'h6D;
      4'd6:    p = 8'h7D;
      4'd7:    p = 8'h07;
      4'd8:    p = 8'h7F;
      4'd9:    p = 8'h6F;
      default: p = SEG_BLANK;
    endcase
    return p;
  endfunction

endpackage

FILE: hw/rtl/ssd_magnitude.sv
// ---------------------------------------------------------------------------
// ssd_magnitude: sign and magnitude stage
// Splits the two's complement input into a sign flag and an unsigned size.
// ---------------------------------------------------------------------------
module ssd_magnitude (
  input  logic              clk,
  input  logic              rst,
  input  logic              up_valid,
  output logic              up_ready,
  input  logic [31:0]       up_value,
  output logic              dn_valid,
  input  logic              dn_ready,
  output ssd_pkg::word_t    dn_word
);
  import ssd_pkg::*;

  word_t dn_word_next;

  // Negate when negative; the most negative value maps onto 2**31
  always_comb begin
    dn_word_next        = '0;
    dn_word_next.neg    = up_value[31];
    dn_word_next.rest   = up_value[31] ? MAG_W'(~up_value + 32'd1) : up_value;
  end

  assign up_ready = !dn_valid || dn_ready;

  // Stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
    if (up_ready && up_valid) begin
      dn_word <= dn_word_next;
    end
  end

endmodule

FILE: hw/rtl/ssd_range.sv
// ---------------------------------------------------------------------------
// ssd_range: overflow check stage
// Flags magnitudes above the largest value the display can show.
// ---------------------------------------------------------------------------
module ssd_range (
  input  logic              clk,
  input  logic              rst,
  input  logic              up_valid,
  output logic              up_ready,
  input  ssd_pkg::word_t    up_word,
  output logic              dn_valid,
  input  logic              dn_ready,
  output ssd_pkg::word_t    dn_word
);
  import ssd_pkg::*;

  word_t dn_word_next;

  // Compare against the decimal limit
  always_comb begin
    dn_word_next     = up_word;
    dn_word_next.ovf = LIMIT_W'(up_word.rest) > LIMIT;
  end

  assign up_ready = !dn_valid || dn_ready;

  // Stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
    if (up_ready && up_valid) begin
      dn_word <= dn_word_next;
    end
  end

endmodule

FILE: hw/rtl/ssd_digit.sv
// ---------------------------------------------------------------------------
// ssd_digit: one decimal digit stage
// Divides the remaining magnitude by ten and shifts the remainder in at the
// top of the digit field; after the last stage the units digit sits at index 0.
// ---------------------------------------------------------------------------
module ssd_digit (
  input  logic              clk,
  input  logic              rst,
  input  logic              up_valid,
  output logic              up_ready,
  input  ssd_pkg::word_t    up_word,
  output logic              dn_valid,
  input  logic              dn_ready,
  output ssd_pkg::word_t    dn_word
);
  import ssd_pkg::*;

  logic [2*MAG_W-1:0]        prod;
  logic [MAG_W-1:0]          quot;
  logic [MAG_W-1:0]          rem;
  logic [4*DIG_STAGES+3:0]   shifted;
  word_t                     dn_word_next;

  // Divide by ten through the reciprocal; remainder by shift and subtract
  always_comb begin
    prod    = {{MAG_W{1'b0}}, up_word.rest} * {{MAG_W{1'b0}}, RECIP_10};
    quot    = MAG_W'(prod >> RECIP_SHIFT);
    rem     = up_word.rest - (quot << 3) - (quot << 1);
    shifted = {rem[3:0], up_word.digits};
    dn_word_next        = up_word;
    dn_word_next.rest   = quot;
    dn_word_next.digits = shifted[4*DIG_STAGES+3:4];
  end

  assign up_ready = !dn_valid || dn_ready;

  // Stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
    if (up_ready && up_valid) begin
      dn_word <= dn_word_next;
    end
  end

endmodule

FILE: hw/rtl/ssd_encode.sv
// ---------------------------------------------------------------------------
// ssd_encode: segment encode and output stage
// Maps digits to patterns, blanks leading zeros, builds the overflow image.
// ---------------------------------------------------------------------------
module ssd_encode (
  input  logic              clk,
  input  logic              rst,
  input  logic              up_valid,
  output logic              up_ready,
  input  ssd_pkg::word_t    up_word,
  output logic              dn_valid,
  input  logic              dn_ready,
  output logic [7:0]        dn_image [ssd_pkg::POSITIONS],
  output logic              dn_overflow
);
  import ssd_pkg::*;

  logic [7:0] image_next [POSITIONS];
  logic       lead;

  // Image build: sign, digits with leading-zero blanking, or oL text
  always_comb begin
    lead = 1'b1;
    for (int p = 0; p < POSITIONS; p++) begin
      image_next[p] = SEG_BLANK;
    end
    if (up_word.neg) begin
      image_next[0] = SEG_MINUS;
    end
    if (up_word.ovf) begin
      image_next[POS_O] = SEG_LOW_O;
      image_next[POS_L] = SEG_CAP_L;
    end else begin
      for (int p = FIRST_POS; p < POSITIONS; p++) begin
        image_next[p] = seg_pattern(up_word.digits[DIGIT_POS - p]);
      end
      for (int p = FIRST_POS; p < DIGIT_POS; p++) begin
        if (lead && up_word.digits[DIGIT_POS - p] == 4'd0) begin
          image_next[p] = SEG_BLANK;
        end else begin
          lead = 1'b0;
        end
      end
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
    if (up_ready && up_valid) begin
      dn_image    <= image_next;
      dn_overflow <= up_word.ovf;
    end
  end

endmodule

FILE: hw/rtl/signed_binary_to_seven_segment.sv
// ---------------------------------------------------------------------------
// signed_binary_to_seven_segment: signed integer to eight-position image
// Pipelined sign split, range check, one decimal digit per stage, encode.
// ---------------------------------------------------------------------------
//  channel | handshake            | word
//  in      | in_valid / in_ready  | value (32-bit signed)
//  out     | out_valid / out_ready| sign_segments, digit1..7_segments, overflow
//
// One word per cycle sustained while out_ready stays high; the stages are
// sign, range check, one divide-by-ten multiplier per digit, then encode
// into the output register.
// Reset clears the valid bits only; the datapath carries no state.
// A stall holds every full stage; empty stages keep filling behind it.
// ---------------------------------------------------------------------------
module signed_binary_to_seven_segment (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  sign_segments,
  output logic [7:0]  digit1_segments,
  output logic [7:0]  digit2_segments,
  output logic [7:0]  digit3_segments,
  output logic [7:0]  digit4_segments,
  output logic [7:0]  digit5_segments,
  output logic [7:0]  digit6_segments,
  output logic [7:0]  digit7_segments,
  output logic        overflow
);
  import ssd_pkg::*;

  logic        mag_valid;
  logic        mag_ready;
  word_t       mag_word;
  logic        dig_valid [DIG_STAGES+1];
  logic        dig_ready [DIG_STAGES+1];
  word_t       dig_word  [DIG_STAGES+1];
  logic [7:0]  image     [POSITIONS];

  // Sign and magnitude
  ssd_magnitude u_magnitude (
    .clk      (clk),
    .rst      (rst),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_value (value),
    .dn_valid (mag_valid),
    .dn_ready (mag_ready),
    .dn_word  (mag_word)
  );

  // Overflow check
  ssd_range u_range (
    .clk      (clk),
    .rst      (rst),
    .up_valid (mag_valid),
    .up_ready (mag_ready),
    .up_word  (mag_word),
    .dn_valid (dig_valid[0]),
    .dn_ready (dig_ready[0]),
    .dn_word  (dig_word[0])
  );

  // Digit stages, units first
  for (genvar k = 0; k < DIG_STAGES; k++) begin : g_digit
    ssd_digit u_digit (
      .clk      (clk),
      .rst      (rst),
      .up_valid (dig_valid[k]),
      .up_ready (dig_ready[k]),
      .up_word  (dig_word[k]),
      .dn_valid (dig_valid[k+1]),
      .dn_ready (dig_ready[k+1]),
      .dn_word  (dig_word[k+1])
    );
  end

  // Encode and output register
  ssd_encode u_encode (
    .clk         (clk),
    .rst         (rst),
    .up_valid    (dig_valid[DIG_STAGES]),
    .up_ready    (dig_ready[DIG_STAGES]),
    .up_word     (dig_word[DIG_STAGES]),
    .dn_valid    (out_valid),
    .dn_ready    (out_ready),
    .dn_image    (image),
    .dn_overflow (overflow)
  );

  assign sign_segments   = image[0];
  assign digit1_segments = image[1];
  assign digit2_segments = image[2];
  assign digit3_segments = image[3];
  assign digit4_segments = image[4];
  assign digit5_segments = image[5];
  assign digit6_segments = image[6];
  assign digit7_segments = image[7];

endmodule

FILE: tb/tb_signed_binary_to_seven_segment.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_signed_binary_to_seven_segment: self-checking bench for the encoder
// Drives signed values through the in channel, predicts each display image
// independently and compares every output word field by field, under random
// idling on both channels.
// ---------------------------------------------------------------------------
module tb_signed_binary_to_seven_segment;

  localparam int DISPLAY_DIGITS = ssd_pkg::NUM_DIGITS;
  localparam int PIPE_LATENCY   = 10;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int RANDOM_WORDS   = 430;

  localparam logic [7:0] MINUS_SEGS = 8'h40;
  localparam logic [7:0] LOW_O_SEGS = 8'h5C;
  localparam logic [7:0] CAP_L_SEGS = 8'h38;
  // gfedcba patterns for 9 down to 0
  localparam logic [9:0][7:0] DIGIT_SEGS = {8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D,
                                            8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F};

  // Display image: seg[0] is the sign position, seg[7] the units digit
  typedef struct packed {
    logic [0:7][7:0] seg;
    logic            ovf;
  } image_t;

  typedef struct packed {
    logic [31:0] v;
    logic        typed;
    image_t      img;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  sign_segments;
  logic [7:0]  digit1_segments;
  logic [7:0]  digit2_segments;
  logic [7:0]  digit3_segments;
  logic [7:0]  digit4_segments;
  logic [7:0]  digit5_segments;
  logic [7:0]  digit6_segments;
  logic [7:0]  digit7_segments;
  logic        overflow;

  image_t    expected_images[$];
  stim_row_t directed_rows[$];
  bit        stalls_on = 1'b1;
  int        mismatches = 0;
  int        images_checked = 0;
  int        words_sent = 0;
  int        neg_count = 0;
  int        ovf_count = 0;
  int        cycles = 0;

  signed_binary_to_seven_segment dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .value           (value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .sign_segments   (sign_segments),
    .digit1_segments (digit1_segments),
    .digit2_segments (digit2_segments),
    .digit3_segments (digit3_segments),
    .digit4_segments (digit4_segments),
    .digit5_segments (digit5_segments),
    .digit6_segments (digit6_segments),
    .digit7_segments (digit7_segments),
    .overflow        (overflow)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Image that a given signed value should produce
  function automatic image_t display_image(input logic [31:0] v);
    image_t      img;
    logic [32:0] mag;
    logic [32:0] rest;
    logic [35:0] lim;
    int          nd;
    int          first;
    bit          lead;
    img = '0;
    // 33-bit negate, so the most negative value needs no special handling
    mag = v[31] ? {1'b0, ~v} + 33'd1 : {1'b0, v};
    nd  = (DISPLAY_DIGITS < 1) ? 1 : ((DISPLAY_DIGITS > 10) ? 10 : DISPLAY_DIGITS);
    lim = 36'd1;
    for (int k = 0; k < nd; k++) lim = lim * 36'd10;
    lim = lim - 36'd1;
    if (v[31]) img.seg[0] = MINUS_SEGS;
    if (36'(mag) > lim) begin
      img.ovf    = 1'b1;
      img.seg[3] = LOW_O_SEGS;
      img.seg[4] = CAP_L_SEGS;
    end else begin
      rest  = mag;
      first = (8 - nd < 1) ? 1 : 8 - nd;
      for (int p = 7; p >= first; p--) begin
        img.seg[p] = DIGIT_SEGS[int'(rest % 33'd10)];
        rest       = rest / 33'd10;
      end
      // blank leading zeros, the units digit always stays
      lead = 1'b1;
      for (int p = first; p < 7; p++) begin
        if (lead && img.seg[p] == DIGIT_SEGS[0]) img.seg[p] = '0;
        else lead = 1'b0;
      end
    end
    return img;
  endfunction

  // Random value biased towards decimal structure and the range edge
  function automatic logic [31:0] random_value();
    logic [31:0] mag;
    int          n;
    mag = '0;
    case ($urandom_range(0, 7)) inside
      0: mag = $urandom_range(0, 99);
      1: mag = $urandom_range(0, 9999);
      [2:3]: mag = $urandom_range(0, 9999999);
      4: mag = $urandom_range(9999990, 10000009);
      5: begin
        // decimal digits with plenty of zeros
        n = $urandom_range(1, 7);
        for (int i = 0; i < n; i++)
          mag = mag * 10 + (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 9));
      end
      default: return $urandom();
    endcase
    return ($urandom_range(0, 1) == 1) ? -mag : mag;
  endfunction

  function automatic string field_name(input int p);
    return (p == 0) ? "sign_segments" : $sformatf("digit%0d_segments", p);
  endfunction

  task automatic add_row(input logic [31:0] v, input logic typed, input image_t img);
    stim_row_t row;
    row.v     = v;
    row.typed = typed;
    row.img   = img;
    directed_rows.push_back(row);
  endtask

  // Offer one word, optionally after an idle burst, and log its image
  task automatic send_word(input stim_row_t row);
    image_t want;
    if (stalls_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      value    <= $urandom();
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= row.v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    want = row.typed ? row.img : display_image(row.v);
    expected_images.push_back(want);
    words_sent++;
    if (want.ovf) ovf_count++;
    if (row.v[31]) neg_count++;
  endtask

  // Hold off the sender until every pending image is out
  task automatic drain_images();
    in_valid <= 1'b0;
    while (expected_images.size() != 0) @(posedge clk);
  endtask

  // Stimulus
  initial begin : stimulus
    stim_row_t row;
    // typed images read left to right: sign, digit1 .. digit7, then overflow
    add_row(32'd0,         1'b1, {64'h00_00_00_00_00_00_00_3F, 1'b0});
    add_row(32'hFFFF_FFFF, 1'b1, {64'h40_00_00_00_00_00_00_06, 1'b0});
    add_row(32'd9999999,   1'b1, {64'h00_6F_6F_6F_6F_6F_6F_6F, 1'b0});
    add_row(-32'sd9999999, 1'b1, {64'h40_6F_6F_6F_6F_6F_6F_6F, 1'b0});
    add_row(32'd10000000,  1'b1, {64'h00_00_00_5C_38_00_00_00, 1'b1});
    add_row(-32'sd10000000, 1'b1, {64'h40_00_00_5C_38_00_00_00, 1'b1});
    add_row(32'h7FFF_FFFF, 1'b1, {64'h00_00_00_5C_38_00_00_00, 1'b1});
    // most negative value overflows but keeps its minus sign
    add_row(32'h8000_0000, 1'b1, {64'h40_00_00_5C_38_00_00_00, 1'b1});
    add_row(32'd1234567,   1'b0, '0);
    add_row(32'd1000000,   1'b0, '0);
    add_row(32'd7,         1'b0, '0);
    add_row(32'd10,        1'b0, '0);
    add_row(32'd100,       1'b0, '0);
    add_row(32'd905,       1'b0, '0);
    add_row(-32'sd42,      1'b0, '0);
    add_row(32'd8080808,   1'b0, '0);
    add_row(32'd3000000,   1'b0, '0);
    add_row(32'd1010101,   1'b0, '0);
    add_row(-32'sd5555555, 1'b0, '0);
    add_row(32'h5555_5555, 1'b0, '0);
    add_row(32'hAAAA_AAAA, 1'b0, '0);
    add_row(32'd9999998,   1'b0, '0);
    add_row(-32'sd10000001, 1'b0, '0);
    add_row(32'd123,       1'b0, '0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < directed_rows.size(); i++) send_word(directed_rows[i]);
    drain_images();

    // random part: idling, a quiet stretch, idling again, quiet tail
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      stalls_on = (i < 150) || (i >= 250 && i < 350);
      if (i == 200) drain_images();
      row.v     = random_value();
      row.typed = 1'b0;
      row.img   = '0;
      send_word(row);
    end
    stalls_on = 1'b0;
    drain_images();
    repeat (2 * PIPE_LATENCY) @(posedge clk);

    $display("Converted %0d values (%0d negative, %0d beyond the display range)",
             words_sent, neg_count, ovf_count);
    $display("Compared %0d images under idling on both channels", images_checked);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Receiver: random bursts of back-pressure while stalls are enabled
  initial begin : receiver
    while (rst) @(posedge clk);
    forever begin
      if (stalls_on && $urandom_range(0, 15) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Output checker
  always @(posedge clk) begin : check_images
    image_t got;
    image_t want;
    bit     bad;
    if (!rst && out_valid && out_ready) begin
      if (expected_images.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected output word, nothing pending", $time);
      end else begin
        want = expected_images.pop_front();
        got  = {sign_segments, digit1_segments, digit2_segments, digit3_segments,
                digit4_segments, digit5_segments, digit6_segments, digit7_segments,
                overflow};
        bad  = 1'b0;
        images_checked++;
        for (int p = 0; p < 8; p++) begin
          if (got.seg[p] !== want.seg[p]) begin
            bad = 1'b1;
            $display("%0t: %s expected %h actual %h", $time, field_name(p),
                     want.seg[p], got.seg[p]);
          end
        end
        if (got.ovf !== want.ovf) begin
          bad = 1'b1;
          $display("%0t: overflow expected %b actual %b", $time, want.ovf, got.ovf);
        end
        if (bad) mismatches++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles, %0d images pending", cycles,
               expected_images.size());
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule
